@@ hw/rtl/wbpm_pkg.sv @@
// Shared types and constants of the wildcard byte pattern matcher.
package wbpm_pkg;

    localparam int MAX_PATTERN_LEN = 32;
    localparam int OFFSET_BITS     = 32;

    localparam int PAT_BYTES  = 32;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 32;
    localparam int MOFS_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic              match;
        logic [MOFS_W-1:0] match_offset;
    } t_out_req;

    // Pattern pre-aligned to window order: entry j pairs with window byte j.
    typedef struct packed {
        logic [MAX_PATTERN_LEN-1:0][7:0] pat;
        logic [MAX_PATTERN_LEN-1:0]      care;
        logic [LEN_W-1:0]                len;
        logic                            len_ok;
    } t_cfg_al;

    typedef struct packed {
        logic                            valid;
        logic [MAX_PATTERN_LEN-1:0][7:0] bytes;
        logic [OFFSET_BITS-1:0]          count;
    } t_win_bus;

endpackage

@@ hw/rtl/wbpm_cfg.sv @@
// Configuration registers and the window-aligned copy of the pattern.
module wbpm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wbpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wbpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wbpm_pkg::t_cfg_al              o_cfg
);
    import wbpm_pkg::*;

    logic [3:0][CFG_DATA_W-1:0] r_pat;
    logic [MASK_W-1:0]          r_care;
    logic [LEN_W-1:0]           r_len;
    t_cfg_al                    r_al;
    t_cfg_al                    n_al;
    logic [PAT_BYTES-1:0][7:0]  pat_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_care <= '0;
            r_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PAT0: r_pat[0] <= i_cfg_data;
                REG_PAT1: r_pat[1] <= i_cfg_data;
                REG_PAT2: r_pat[2] <= i_cfg_data;
                REG_PAT3: r_pat[3] <= i_cfg_data;
                REG_CARE: r_care   <= i_cfg_data[MASK_W-1:0];
                REG_LEN:  r_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_bytes = r_pat;

    // Window byte j meets pattern byte len-1-j; positions past len are don't-care.
    always_comb begin
        logic [LEN_W-1:0] k;
        n_al        = '0;
        n_al.len    = r_len;
        n_al.len_ok = (r_len != '0) && ({1'b0, r_len} <= (LEN_W+1)'(MAX_PATTERN_LEN));
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            k = r_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < r_len) begin
                n_al.pat[j]  = pat_bytes[k[4:0]];
                n_al.care[j] = r_care[k[4:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al <= '0;
        end else begin
            r_al <= n_al;
        end
    end

    assign o_cfg = r_al;

endmodule

@@ hw/rtl/wbpm_window.sv @@
// Input side: byte shift window, per-buffer byte count and the input register.
module wbpm_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wbpm_pkg::t_in_req   i_in_data,
    input  logic                i_take,
    output wbpm_pkg::t_win_bus  o_win
);
    import wbpm_pkg::*;

    logic                            r_valid;
    logic                            r_clear;
    logic [MAX_PATTERN_LEN-1:0][7:0] r_win;
    logic [OFFSET_BITS-1:0]          r_cnt;
    logic [MAX_PATTERN_LEN-1:0][7:0] n_win;
    logic [OFFSET_BITS-1:0]          n_cnt;
    logic [MAX_PATTERN_LEN-1:0][7:0] base_win;
    logic [OFFSET_BITS-1:0]          base_cnt;
    logic                            accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    // A last byte leaves r_clear set: the next byte starts from an empty window.
    assign base_win = r_clear ? '0 : r_win;
    assign base_cnt = r_clear ? '0 : r_cnt;

    always_comb begin
        for (int j = MAX_PATTERN_LEN - 1; j > 0; j--) begin
            n_win[j] = base_win[j-1];
        end
        n_win[0] = i_in_data.data_byte;
        n_cnt    = (base_cnt == '1) ? base_cnt : base_cnt + OFFSET_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_clear <= 1'b0;
            r_win   <= '0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_clear <= i_in_data.last_byte;
                r_win   <= n_win;
                r_cnt   <= n_cnt;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_win.valid = r_valid;
    assign o_win.bytes = r_win;
    assign o_win.count = r_cnt;

`ifndef SYNTHESIS
    a_last_sets_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.last_byte |=> r_clear)
        else $error("window not restarted after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !r_clear && r_cnt != '1 |=> r_cnt == $past(r_cnt) + OFFSET_BITS'(1))
        else $error("byte count did not advance");
`endif

endmodule

@@ hw/rtl/wbpm_match.sv @@
// Masked parallel compare of the window and the result register.
module wbpm_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbpm_pkg::t_win_bus  i_win,
    input  wbpm_pkg::t_cfg_al   i_cfg,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wbpm_pkg::t_out_req  o_out_data
);
    import wbpm_pkg::*;

    logic                       r_valid;
    t_out_req                   r_data;
    t_out_req                   n_data;
    logic [MAX_PATTERN_LEN-1:0] byte_ok;
    logic [OFFSET_BITS-1:0]     len_ext;
    logic [OFFSET_BITS-1:0]     offset;
    logic                       hit;

    assign o_take = !r_valid || !i_out_stall;

    always_comb begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            byte_ok[j] = !i_cfg.care[j] || (i_cfg.pat[j] == i_win.bytes[j]);
        end
    end

    assign len_ext = OFFSET_BITS'(i_cfg.len);
    assign offset  = i_win.count - len_ext;
    assign hit     = i_cfg.len_ok && (i_win.count >= len_ext) && (&byte_ok);

    assign n_data.match        = hit;
    assign n_data.match_offset = hit ? MOFS_W'(offset) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_win.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_win.valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

`ifndef SYNTHESIS
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_win.valid |=> o_out_valid)
        else $error("compared request produced no result");

    a_offset_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.match |-> o_out_data.match_offset == '0)
        else $error("offset nonzero without match");
`endif

endmodule

@@ hw/rtl/wildcard_byte_pattern_matcher_core.sv @@
// Top level of the wildcard byte pattern matcher.
// Streams buffer bytes at one request per clock while results drain and returns one
// result per byte: the byte shifts into a 32-byte window register, then all
// window positions are compared against the pattern in parallel under the care mask and
// the result register is loaded. A new byte is taken every cycle as long as results drain;
// a waiting result stalls input only once the window stage also holds a byte. The result
// reports a match ending at this byte and the buffer offset of its first byte; last_byte
// restarts the window and the saturating offset count. Config writes go through the
// config registers and the aligned copy, and must be done while no bytes are in flight.
module wildcard_byte_pattern_matcher_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  wbpm_pkg::t_in_req               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output wbpm_pkg::t_out_req              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [wbpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wbpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wbpm_pkg::*;

    t_cfg_al  cfg_al;
    t_win_bus win;
    logic     take;

    wbpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg_al)
    );

    wbpm_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_take     (take),
        .o_win      (win)
    );

    wbpm_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (win),
        .i_cfg       (cfg_al),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
